// ===== rtl/ovl_pkg.sv =====
`default_nettype none

package ovl_pkg;

	localparam int CAPACITY    = 16;
	localparam int VALUE_WIDTH = 32;
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam int FUNC_W   = 2;
	localparam int KEY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;
	localparam int COUNT_W  = 5;

	typedef enum logic [FUNC_W-1:0] {
		FN_APPEND = 2'd0,
		FN_ERASE  = 2'd1,
		FN_SEARCH = 2'd2,
		FN_CHANGE = 2'd3
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE     = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic                   append;
		logic                   erase;
		logic                   change;
		logic [VALUE_WIDTH-1:0] key;
		logic [VALUE_WIDTH-1:0] rep;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/ordered_value_list_core.sv =====
// The result register decouples out; a result is valid in the cycle after its
// request is accepted. Throughput: one request per cycle while out_ready takes
// each result; all cells compare with the key and shift in the same cycle.
// Reset: occupancy and result valid clear asynchronously; the entry cells
// hold no reset value and are read only once written.
`default_nettype none

module ordered_value_list_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_ready,
	input  wire logic [ovl_pkg::FUNC_W-1:0]      func,
	input  wire logic [ovl_pkg::KEY_W-1:0]       key_value,
	input  wire logic [ovl_pkg::KEY_W-1:0]       replacement,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic      [ovl_pkg::STATUS_W-1:0]    status,
	output logic      [ovl_pkg::POS_W-1:0]       position,
	output logic      [ovl_pkg::COUNT_W-1:0]     entry_count
);

	localparam int CAP     = ovl_pkg::CAPACITY;
	localparam int CNT_W   = ovl_pkg::CNT_W;
	localparam int IDX_W   = ovl_pkg::IDX_W;
	localparam int VW      = ovl_pkg::VALUE_WIDTH;
	localparam int POS_W   = ovl_pkg::POS_W;
	localparam int COUNT_W = ovl_pkg::COUNT_W;

	logic                    req;
	ovl_pkg::func_t          fn;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_next;
	logic                    full;
	logic                    any_hit;
	logic [CAP:0]            hit_chain;
	logic [CAP-1:0]          first_hit;
	logic [VW-1:0]           cell_value [CAP];
	logic [IDX_W-1:0]        hit_idx;
	ovl_pkg::cell_ctrl_t     ctrl;
	ovl_pkg::status_t        status_d;
	logic [IDX_W-1:0]        pos_d;
	logic                    out_valid_q;
	ovl_pkg::status_t        status_q;
	logic [POS_W-1:0]        pos_q;

	assign in_ready  = !out_valid_q || out_ready;
	assign req       = in_valid && in_ready;
	assign fn        = ovl_pkg::func_t'(func);
	assign full      = (count_q >= CNT_W'(CAP));
	assign any_hit   = hit_chain[CAP];
	assign hit_chain[0] = 1'b0;

	assign ctrl.append = req && (fn == ovl_pkg::FN_APPEND) && !full;
	assign ctrl.erase  = req && (fn == ovl_pkg::FN_ERASE) && any_hit;
	assign ctrl.change = req && (fn == ovl_pkg::FN_CHANGE) && any_hit;
	assign ctrl.key    = key_value[VW-1:0];
	assign ctrl.rep    = replacement[VW-1:0];

	for (genvar g = 0; g < CAP; g++) begin : g_cell
		logic [VW-1:0] nxt;
		if (g == CAP - 1) begin : g_last
			assign nxt = '0;
		end else begin : g_mid
			assign nxt = cell_value[g+1];
		end
		ovl_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.live       (CNT_W'(g) < count_q),
			.tail       (CNT_W'(g) == count_q),
			.prior_hit  (hit_chain[g]),
			.next_value (nxt),
			.value      (cell_value[g]),
			.hit_out    (hit_chain[g+1]),
			.first_hit  (first_hit[g])
		);
	end

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < CAP; i++) begin
			if (first_hit[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	always_comb begin
		status_d   = ovl_pkg::ST_DONE;
		pos_d      = '0;
		count_next = count_q;
		case (fn)
			ovl_pkg::FN_APPEND: begin
				if (full) begin
					status_d = ovl_pkg::ST_FULL;
				end else begin
					pos_d      = count_q[IDX_W-1:0];
					count_next = count_q + CNT_W'(1);
				end
			end
			default: begin
				if (count_q == '0) begin
					status_d = ovl_pkg::ST_EMPTY;
				end else if (!any_hit) begin
					status_d = ovl_pkg::ST_NOTFOUND;
				end else begin
					pos_d = hit_idx;
					if (fn == ovl_pkg::FN_ERASE) begin
						count_next = count_q - CNT_W'(1);
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (req) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req) begin
			status_q <= status_d;
			pos_q    <= POS_W'(pos_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = pos_q;
	assign entry_count = COUNT_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAP))
		else $error("occupancy above capacity");

	a_single_first: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_hit))
		else $error("more than one first match");

	a_full_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req && (fn == ovl_pkg::FN_APPEND) && full |=> count_q == $past(count_q))
		else $error("append to full list changed occupancy");

	a_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != ovl_pkg::ST_DONE) |-> pos_q == '0)
		else $error("nonzero position on failed request");

	a_hit_live: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> !any_hit)
		else $error("match reported in empty list");

endmodule

`default_nettype wire

// ===== rtl/ovl_cell.sv =====
`default_nettype none

module ovl_cell (
	input  wire logic                           clk,
	input  wire ovl_pkg::cell_ctrl_t            ctrl,
	input  wire logic                           live,
	input  wire logic                           tail,
	input  wire logic                           prior_hit,
	input  wire logic [ovl_pkg::VALUE_WIDTH-1:0] next_value,
	output logic      [ovl_pkg::VALUE_WIDTH-1:0] value,
	output logic                                hit_out,
	output logic                                first_hit
);

	logic [ovl_pkg::VALUE_WIDTH-1:0] value_q;
	logic                            eq;

	assign eq        = live && (value_q == ctrl.key);
	assign first_hit = eq && !prior_hit;
	assign hit_out   = prior_hit || eq;
	assign value     = value_q;

	// take the key at the tail, shift down behind an erased entry, or overwrite
	always_ff @(posedge clk) begin
		if (ctrl.append && tail) begin
			value_q <= ctrl.key;
		end else if (ctrl.erase && live && hit_out) begin
			value_q <= next_value;
		end else if (ctrl.change && first_hit) begin
			value_q <= ctrl.rep;
		end
	end

endmodule

`default_nettype wire
